FILE: rtl/qrr_pkg.sv
// ----------------------------------------------------------------------------
// qrr_pkg: shared types and constants for the quota round-robin drain
// packet and result layouts, tag codes and the queue entry between front and back
// ----------------------------------------------------------------------------
package qrr_pkg;

	localparam int ADDR_W     = 24;
	localparam int DATA_W     = 64;
	localparam int QCNT_W     = 7;
	localparam int PART_W     = 14;
	localparam int NUM_SRC    = 3;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W     = 1;
	localparam int QCNT_FILL_W = 2;

	localparam logic [1:0] SRC_LAST = 2'd2;
	localparam logic [NUM_SRC-1:0] ALL_FINISHED = 3'b111;

	typedef enum logic [1:0] {
		TAG_DATA = 2'd0,
		TAG_SOD  = 2'd1,
		TAG_EOD  = 2'd2,
		TAG_EOS  = 2'd3
	} tag_t;

	typedef struct packed {
		logic [1:0]        packet_tag;
		logic [DATA_W-1:0] packet_payload;
	} packet_t;

	typedef struct packed {
		logic              write_enable;
		logic [ADDR_W-1:0] write_address;
		logic [DATA_W-1:0] write_data;
		logic [1:0]        next_source;
		logic              all_done;
	} result_t;

	// classified item waiting for the back end
	typedef struct packed {
		logic              write_enable;
		logic [ADDR_W-1:0] write_count;
		logic [DATA_W-1:0] write_data;
		logic [1:0]        next_source;
		logic              all_done;
	} entry_t;

endpackage

FILE: rtl/qrr_front.sv
// ----------------------------------------------------------------------------
// qrr_front: packet intake and source arbitration
// keeps the round-robin state, classifies each packet and emits a queue entry
// ----------------------------------------------------------------------------
module qrr_front #(
	parameter int QUOTA_SOURCE0 = 4,
	parameter int QUOTA_SOURCE1 = 4,
	parameter int QUOTA_SOURCE2 = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  qrr_pkg::packet_t packet,
	output qrr_pkg::entry_t  entry
);
	import qrr_pkg::*;

	logic [1:0]         src_q, src_n;
	logic [QCNT_W-1:0]  quota_cnt_q, quota_cnt_n;
	logic [NUM_SRC-1:0] finished_q, finished_n;
	logic [ADDR_W-1:0]  written_q, written_n;
	logic               is_data;

	function automatic logic [QCNT_W-1:0] quota_of(input logic [1:0] src);
		logic [QCNT_W-1:0] q;
		case (src)
			2'd0:    q = QCNT_W'(QUOTA_SOURCE0);
			2'd1:    q = QCNT_W'(QUOTA_SOURCE1);
			default: q = QCNT_W'(QUOTA_SOURCE2);
		endcase
		return q;
	endfunction

	always_comb begin
		src_n       = src_q;
		quota_cnt_n = quota_cnt_q;
		finished_n  = finished_q;
		written_n   = written_q;
		is_data     = 1'b0;
		if (finished_q != ALL_FINISHED) begin
			if (packet.packet_tag == TAG_EOS) begin
				finished_n[src_q] = 1'b1;
			end else if (packet.packet_tag == TAG_DATA) begin
				is_data   = 1'b1;
				written_n = written_q + ADDR_W'(1);
			end
			quota_cnt_n = quota_cnt_q + QCNT_W'(1);
			// advance past exhausted or finished sources, at most one full lap
			for (int m = 0; m < NUM_SRC; m++) begin
				if (finished_n != ALL_FINISHED &&
				    (finished_n[src_n] || quota_cnt_n >= quota_of(src_n))) begin
					src_n       = (src_n == SRC_LAST) ? 2'd0 : src_n + 2'd1;
					quota_cnt_n = '0;
				end
			end
		end
		entry.write_enable = is_data;
		entry.write_count  = written_q;
		entry.write_data   = is_data ? packet.packet_payload : '0;
		entry.next_source  = src_n;
		entry.all_done     = (finished_n == ALL_FINISHED);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q       <= '0;
			quota_cnt_q <= '0;
			finished_q  <= '0;
			written_q   <= '0;
		end else if (accept) begin
			src_q       <= src_n;
			quota_cnt_q <= quota_cnt_n;
			finished_q  <= finished_n;
			written_q   <= written_n;
		end
	end

endmodule

FILE: rtl/qrr_queue.sv
// ----------------------------------------------------------------------------
// qrr_queue: short queue between front and back
// two entries, so each side can stall without holding the other
// ----------------------------------------------------------------------------
module qrr_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  qrr_pkg::entry_t wr_entry,
	output logic            full,
	input  logic            rd_en,
	output logic            rd_valid,
	output qrr_pkg::entry_t rd_entry
);
	import qrr_pkg::*;

	entry_t                 mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0]      wr_ptr_q, rd_ptr_q;
	logic [QCNT_FILL_W-1:0] fill_q;

	assign full     = (fill_q == QCNT_FILL_W'(QUEUE_DEPTH));
	assign rd_valid = (fill_q != '0);
	assign rd_entry = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (rd_en) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			case ({wr_en, rd_en})
				2'b10:   fill_q <= fill_q + QCNT_FILL_W'(1);
				2'b01:   fill_q <= fill_q - QCNT_FILL_W'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

FILE: rtl/qrr_back.sv
// ----------------------------------------------------------------------------
// qrr_back: address generation and result register
// holds the block base, forms the write address and presents the result
// ----------------------------------------------------------------------------
module qrr_back #(
	parameter int PACKETS_PER_BLOCK = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [qrr_pkg::PART_W-1:0]    cfg_data,
	input  logic                          q_valid,
	input  qrr_pkg::entry_t               q_entry,
	output logic                          q_take,
	output logic                          empty,
	input  logic                          pop,
	output qrr_pkg::result_t              result
);
	import qrr_pkg::*;

	localparam int PROD_W = PART_W + $clog2(PACKETS_PER_BLOCK + 1);

	logic [PROD_W-1:0] base_prod;
	logic [ADDR_W-1:0] base_q;
	logic              valid_q;
	result_t           result_q;

	// user changes base only while idle, unenforced; formed once per write
	assign base_prod = PROD_W'(cfg_data) * PROD_W'(PACKETS_PER_BLOCK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_valid) begin
			base_q <= base_prod[ADDR_W-1:0];
		end
	end

	assign q_take = q_valid && (!valid_q || pop);
	assign empty  = !valid_q;
	assign result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_take) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_take) begin
			result_q.write_enable  <= q_entry.write_enable;
			result_q.write_address <= q_entry.write_enable ?
			                          base_q + q_entry.write_count : '0;
			result_q.write_data    <= q_entry.write_data;
			result_q.next_source   <= q_entry.next_source;
			result_q.all_done      <= q_entry.all_done;
		end
	end

endmodule

FILE: rtl/quota_round_robin_result_drain_unit.sv
// ----------------------------------------------------------------------------
// quota_round_robin_result_drain_unit: weighted round-robin drain of three
// result streams into one sequential memory write stream
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  packet   | push / full           | packet_t: packet_tag, packet_payload
//  result   | pop / empty           | result_t: write_enable, write_address,
//           |                       |           write_data, next_source, all_done
//  config   | cfg_valid / cfg_ready | cfg_data: partition_index (14 bits)
//
// one item per cycle sustained in and out while the reader keeps popping; an item
// is written to the queue when accepted and moves to the result register when taken
// the arbitration update (quota count, source advance) is combinational logic
// in the front end, the address add sits in the back end result register
// reset clears source state, write count, block base, queue and result valid
// full rises only when the two-entry queue and the result register are all
// occupied, so a stalled reader costs nothing until three items pile up
// ----------------------------------------------------------------------------
module quota_round_robin_result_drain_unit #(
	parameter int QUOTA_SOURCE0     = 4,
	parameter int QUOTA_SOURCE1     = 4,
	parameter int QUOTA_SOURCE2     = 4,
	parameter int PACKETS_PER_BLOCK = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// packet intake
	input  logic                       push,
	output logic                       full,
	input  qrr_pkg::packet_t           packet,
	// result drain
	output logic                       empty,
	input  logic                       pop,
	output qrr_pkg::result_t           result,
	// partition index register
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [qrr_pkg::PART_W-1:0] cfg_data
);
	import qrr_pkg::*;

	logic   accept;
	entry_t front_entry;
	logic   q_valid;
	logic   q_take;
	entry_t q_entry;

	// config is always taken at once
	assign cfg_ready = 1'b1;

	// an item enters whenever the queue has room
	assign accept = push && !full;

	// front: arbitration state and classification
	qrr_front #(
		.QUOTA_SOURCE0(QUOTA_SOURCE0),
		.QUOTA_SOURCE1(QUOTA_SOURCE1),
		.QUOTA_SOURCE2(QUOTA_SOURCE2)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.packet (packet),
		.entry  (front_entry)
	);

	// decoupling queue
	qrr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (accept),
		.wr_entry (front_entry),
		.full     (full),
		.rd_en    (q_take),
		.rd_valid (q_valid),
		.rd_entry (q_entry)
	);

	// back: address generation and result register
	qrr_back #(
		.PACKETS_PER_BLOCK(PACKETS_PER_BLOCK)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.q_take    (q_take),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule
